@@ rtl/vcdv_pkg.sv @@
// ----------------------------------------------------------------------------
// vcdv_pkg
// Shared types, constants and helper functions of the VIN check-digit
// validator.
// ----------------------------------------------------------------------------
package vcdv_pkg;

    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned VALUE_W    = 4;
    localparam int unsigned WEIGHT_W   = 4;
    localparam int unsigned COUNT_W    = 5;
    localparam int unsigned SUM_W      = 4;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW   = $clog2(QUEUE_DEPTH);

    localparam logic [COUNT_W-1:0] VIN_LENGTH     = COUNT_W'(17);
    localparam logic [COUNT_W-1:0] CHECK_POSITION = COUNT_W'(8);
    localparam logic [COUNT_W-1:0] COUNT_SATURATE = COUNT_W'(18);
    localparam logic [SUM_W-1:0]   REMAINDER_TEN  = SUM_W'(10);

    localparam logic [CHAR_W-1:0] ASCII_0       = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_9       = 8'h39;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] ASCII_X       = 8'h58;
    localparam logic [CHAR_W-1:0] CASE_OFFSET   = 8'h20;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISMATCH  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_LENGTH    = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD_CHAR  = 2'd3;

    // Classified character as it travels from front to back.
    typedef struct packed {
        logic [CHAR_W-1:0]  folded;
        logic [VALUE_W-1:0] value;
        logic               bad;
        logic               last;
    } char_class_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                valid_res;
    } result_t;

    function automatic logic [VALUE_W-1:0] letter_value(input logic [4:0] idx);
        logic [VALUE_W-1:0] v;
        unique case (idx)
            5'd0:    v = 4'd1;
            5'd1:    v = 4'd2;
            5'd2:    v = 4'd3;
            5'd3:    v = 4'd4;
            5'd4:    v = 4'd5;
            5'd5:    v = 4'd6;
            5'd6:    v = 4'd7;
            5'd7:    v = 4'd8;
            5'd8:    v = 4'd0;
            5'd9:    v = 4'd1;
            5'd10:   v = 4'd2;
            5'd11:   v = 4'd3;
            5'd12:   v = 4'd4;
            5'd13:   v = 4'd5;
            5'd14:   v = 4'd0;
            5'd15:   v = 4'd7;
            5'd16:   v = 4'd0;
            5'd17:   v = 4'd9;
            5'd18:   v = 4'd2;
            5'd19:   v = 4'd3;
            5'd20:   v = 4'd4;
            5'd21:   v = 4'd5;
            5'd22:   v = 4'd6;
            5'd23:   v = 4'd7;
            5'd24:   v = 4'd8;
            5'd25:   v = 4'd9;
            default: v = 4'd0;
        endcase
        return v;
    endfunction

    function automatic logic [WEIGHT_W-1:0] position_weight(input logic [COUNT_W-1:0] pos);
        logic [WEIGHT_W-1:0] w;
        unique case (pos)
            5'd0:    w = 4'd8;
            5'd1:    w = 4'd7;
            5'd2:    w = 4'd6;
            5'd3:    w = 4'd5;
            5'd4:    w = 4'd4;
            5'd5:    w = 4'd3;
            5'd6:    w = 4'd2;
            5'd7:    w = 4'd10;
            5'd8:    w = 4'd0;
            5'd9:    w = 4'd9;
            5'd10:   w = 4'd8;
            5'd11:   w = 4'd7;
            5'd12:   w = 4'd6;
            5'd13:   w = 4'd5;
            5'd14:   w = 4'd4;
            5'd15:   w = 4'd3;
            5'd16:   w = 4'd2;
            default: w = 4'd0;
        endcase
        return w;
    endfunction

    // x mod 11 for x <= 100: quotient by reciprocal 187/2048.
    function automatic logic [SUM_W-1:0] mod11(input logic [7:0] x);
        logic [15:0] prod;
        logic [4:0]  q;
        logic [7:0]  r;
        prod = 16'(x) * 16'd187;
        q    = prod[15:11];
        r    = x - 8'(q) * 8'd11;
        return r[SUM_W-1:0];
    endfunction

endpackage

@@ rtl/vcdv_front.sv @@
// ----------------------------------------------------------------------------
// vcdv_front
// Front end: folds case and classifies each incoming character.
// ----------------------------------------------------------------------------
module vcdv_front
(
    input  logic [vcdv_pkg::CHAR_W-1:0] character,
    input  logic                        last,
    output vcdv_pkg::char_class_t       cls
);

    logic [vcdv_pkg::CHAR_W-1:0] folded;
    logic                        is_lower;
    logic                        is_digit;
    logic                        is_upper;
    logic [4:0]                  letter_idx;

    always_comb
    begin
        is_lower   = (character >= vcdv_pkg::ASCII_LOWER_A) &&
                     (character <= vcdv_pkg::ASCII_LOWER_Z);
        folded     = is_lower ? (character - vcdv_pkg::CASE_OFFSET) : character;
        is_digit   = (folded >= vcdv_pkg::ASCII_0) && (folded <= vcdv_pkg::ASCII_9);
        is_upper   = (folded >= vcdv_pkg::ASCII_UPPER_A) &&
                     (folded <= vcdv_pkg::ASCII_UPPER_Z);
        letter_idx = 5'(folded - vcdv_pkg::ASCII_UPPER_A);

        cls.folded = folded;
        cls.last   = last;
        cls.bad    = !(is_digit || is_upper);
        if (is_digit)
        begin
            cls.value = folded[vcdv_pkg::VALUE_W-1:0];
        end
        else if (is_upper)
        begin
            cls.value = vcdv_pkg::letter_value(letter_idx);
        end
        else
        begin
            cls.value = '0;
        end
    end

endmodule

@@ rtl/vcdv_queue.sv @@
// ----------------------------------------------------------------------------
// vcdv_queue
// Short FIFO of classified characters between front and back.
// ----------------------------------------------------------------------------
module vcdv_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  vcdv_pkg::char_class_t push_data,
    input  logic                  pop,
    output vcdv_pkg::char_class_t head,
    output logic                  full,
    output logic                  empty
);

    vcdv_pkg::char_class_t entry_reg [vcdv_pkg::QUEUE_DEPTH];

    logic [vcdv_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [vcdv_pkg::QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [vcdv_pkg::QUEUE_AW:0]   count_reg,  count_next;

    assign full  = (count_reg == (vcdv_pkg::QUEUE_AW+1)'(vcdv_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/vcdv_back.sv @@
// ----------------------------------------------------------------------------
// vcdv_back
// Back end: weighted mod-11 accumulation, status decision, output register.
// ----------------------------------------------------------------------------
module vcdv_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  vcdv_pkg::char_class_t head,
    input  logic                  empty,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output vcdv_pkg::result_t     out_result
);

    logic [vcdv_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [vcdv_pkg::SUM_W-1:0]   sum_reg,   sum_next;
    logic [vcdv_pkg::CHAR_W-1:0]  check_reg, check_next;
    logic                         bad_reg,   bad_next;
    logic                         out_valid_reg, out_valid_next;
    vcdv_pkg::result_t            result_reg, result_next;

    logic [vcdv_pkg::COUNT_W-1:0]  count_inc;
    logic [vcdv_pkg::SUM_W-1:0]    sum_new;
    logic [vcdv_pkg::CHAR_W-1:0]   check_new;
    logic                          bad_new;
    logic [7:0]                    product;
    logic [7:0]                    total;
    logic [vcdv_pkg::CHAR_W-1:0]   expected;
    logic [vcdv_pkg::STATUS_W-1:0] status;

    assign pop        = !empty && (!head.last || !out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

    always_comb
    begin
        product   = 8'(head.value) * 8'(vcdv_pkg::position_weight(count_reg));
        total     = 8'(sum_reg) + product;
        sum_new   = vcdv_pkg::mod11(total);
        count_inc = (count_reg < vcdv_pkg::COUNT_SATURATE) ? count_reg + 1'b1 : count_reg;
        check_new = (count_reg == vcdv_pkg::CHECK_POSITION) ? head.folded : check_reg;
        bad_new   = bad_reg | head.bad;
        expected  = (sum_new == vcdv_pkg::REMAINDER_TEN) ? vcdv_pkg::ASCII_X
                                                         : vcdv_pkg::ASCII_0 + 8'(sum_new);
        priority if (count_inc != vcdv_pkg::VIN_LENGTH)
        begin
            status = vcdv_pkg::STATUS_LENGTH;
        end
        else if (bad_new)
        begin
            status = vcdv_pkg::STATUS_BAD_CHAR;
        end
        else if (check_new != expected)
        begin
            status = vcdv_pkg::STATUS_MISMATCH;
        end
        else
        begin
            status = vcdv_pkg::STATUS_OK;
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        sum_next       = sum_reg;
        check_next     = check_reg;
        bad_next       = bad_reg;
        out_valid_next = out_valid_reg && !out_ready;
        result_next    = result_reg;
        if (pop)
        begin
            if (head.last)
            begin
                count_next            = '0;
                sum_next              = '0;
                check_next            = '0;
                bad_next              = 1'b0;
                out_valid_next        = 1'b1;
                result_next.status    = status;
                result_next.valid_res = (status == vcdv_pkg::STATUS_OK);
            end
            else
            begin
                count_next = count_inc;
                sum_next   = sum_new;
                check_next = check_new;
                bad_next   = bad_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sum_reg       <= '0;
            check_reg     <= '0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            check_reg     <= check_next;
            bad_reg       <= bad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule

@@ rtl/vin_check_digit_validator_unit.sv @@
// ----------------------------------------------------------------------------
// vin_check_digit_validator_unit
// Mod-11 check-digit validator for vehicle identification numbers.
// ----------------------------------------------------------------------------
// Input stream: one ASCII character per word on s_axis, tlast on the final
// character of a number. Output stream: one result word on m_axis per number,
// issued for the word carrying tlast; no word for the other characters.
// Path: the tlast word is classified by the front into the FIFO at the
// accepting edge, then accumulated by the back end into the output
// register, from which m_axis presents the result. Throughput: one
// character per cycle while m_axis takes results, limited by the single
// accumulate step of the back end; consecutive numbers need no gap.
// Reset clears the FIFO, the running count, sum, check character and error
// flag, and the output valid. When m_axis stalls, the pending result holds
// in the output register; the back end keeps consuming characters of the
// next number and stops only at its tlast word, after which the 4-word FIFO
// fills and s_axis_tready drops.
// ----------------------------------------------------------------------------
module vin_check_digit_validator_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] character
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] valid_res, [2:1] status, [7:3] zero
);

    vcdv_pkg::char_class_t cls;
    vcdv_pkg::char_class_t head;
    vcdv_pkg::result_t     result;
    logic                  full;
    logic                  empty;
    logic                  push;
    logic                  pop;

    assign s_axis_tready = !full;
    assign push          = s_axis_tvalid && !full;
    assign m_axis_tdata  = {5'b0, result.status, result.valid_res};

    vcdv_front u_front
    (
        .character (s_axis_tdata),
        .last      (s_axis_tlast),
        .cls       (cls)
    );

    vcdv_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (cls),
        .pop       (pop),
        .head      (head),
        .full      (full),
        .empty     (empty)
    );

    vcdv_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .empty      (empty),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

endmodule

@@ rtl/vcdv_checker.sv @@
// ----------------------------------------------------------------------------
// vcdv_checker
// Port-level checks of the VIN check-digit validator.
// ----------------------------------------------------------------------------
module vcdv_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic       s_axis_tlast,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |=>
            s_axis_tvalid && $stable({s_axis_tlast, s_axis_tdata}))
        else $error("input word changed while stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_flag_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[2:1] == 2'd0)))
        else $error("valid_res disagrees with status");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("result valid during reset");

endmodule

bind vin_check_digit_validator_unit vcdv_checker u_vcdv_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
